### hdl/pld_pkg.sv
// Shared types, result codes and the header digit decoder for the line deframer.
package pld_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_FLUSH = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_CLEAN = 3'd4;

    localparam logic [1:0] ERR_CHAR   = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_HUNGUP = 2'd2;

    localparam logic [1:0] REG_BUFFER_SIZE = 2'd0;
    localparam logic [1:0] REG_CHOMP       = 2'd1;
    localparam logic [1:0] REG_EOF_CLEAN   = 2'd2;

    localparam logic [16:0] BUFFER_SIZE_RESET = 17'd65520;
    localparam logic [15:0] HEADER_BYTES      = 16'd4;
    localparam logic [7:0]  CHAR_NEWLINE      = 8'h0A;
    localparam logic [4:0]  HEX_INVALID       = 5'd16;

    typedef struct packed {
        logic [16:0] buffer_size;
        logic        chomp_newline;
        logic        eof_is_clean;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_length;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [2:0] count;
        logic       room;
    } t_q_status;

    // Value of an ASCII hex digit, or HEX_INVALID for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            if (c inside {[8'h30:8'h39]}) begin
                v = {1'b0, c[3:0]};
            end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
                v = 5'({1'b0, c[3:0]} + 5'd9);
            end else begin
                v = HEX_INVALID;
            end
            return v;
        end
    endfunction

endpackage

### hdl/pkt_line_deframer.sv
// Top level of the length-prefixed line deframer: input register, configuration and result queue.
//
// The block takes one source byte per request and splits the stream into packets, each opened by
// four hex digits giving the packet length including the header. A length of zero is a flush; a
// length of four or more carries length minus four payload bytes, which are passed on one byte
// late so that a trailing newline can be removed when chomping is enabled. Each request yields
// zero to three result requests: most payload and header bytes give at most one, while the last
// byte of a payload gives up to three (held byte, last byte, packet end). A byte is taken every
// cycle while the queue has room for a full set of results; results wait in the four-slot result
// queue, which empties one entry per cycle while the output is not stalled. An accepted byte
// passes the input register and then the result queue before its first result appears. Any
// error returns the parser to header parsing with the next byte. The user must see that
// configuration registers are written only while the block is idle, which it does not enforce.
module pkt_line_deframer
    import pld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_payload_length,
    output logic [1:0]  o_error_code,
    output logic        o_last_of_run
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eoi;

    logic       parse_en;
    logic       in_accept;
    logic       pop;
    t_result    parse_res [MAX_RESULTS];
    logic [1:0] parse_count;
    t_result    head;
    t_q_status  q_status;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.buffer_size   <= BUFFER_SIZE_RESET;
            r_cfg.chomp_newline <= 1'b0;
            r_cfg.eof_is_clean  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUFFER_SIZE: r_cfg.buffer_size   <= i_cfg_data;
                REG_CHOMP:       r_cfg.chomp_newline <= i_cfg_data[0];
                REG_EOF_CLEAN:   r_cfg.eof_is_clean  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The registered byte is parsed once the queue can take a full set of its results.
    assign pop        = o_out_valid && !i_out_stall;
    assign parse_en   = r_in_valid && q_status.room;
    assign o_in_stall = r_in_valid && !q_status.room;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (parse_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    pld_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (parse_en),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .i_cfg   (r_cfg),
        .o_res   (parse_res),
        .o_count (parse_count)
    );

    pld_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (parse_en),
        .i_push_count (parse_count),
        .i_res        (parse_res),
        .i_pop        (pop),
        .o_head       (head),
        .o_status     (q_status)
    );

    assign o_out_valid      = (q_status.count != 3'd0);
    assign o_kind           = head.kind;
    assign o_data_byte      = head.data_byte;
    assign o_payload_length = head.payload_length;
    assign o_error_code     = head.error_code;
    assign o_last_of_run    = head.last_of_run;

`ifndef SYNTHESIS
    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= 3'(QUEUE_DEPTH))
        else $error("result queue holds more entries than it has slots");

    a_eoi_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (parse_en && r_in_eoi) |=> (q_status.count != 3'd0))
        else $error("end of input produced no result");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && q_status.count >= 3'd2))
        else $error("input stalled without a waiting byte and a busy queue");
`endif

endmodule

### hdl/pld_parse.sv
// Header and payload parser: holds the framing state and forms up to three results per byte.
module pld_parse
    import pld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    input  t_cfg       i_cfg,
    output t_result    o_res [MAX_RESULTS],
    output logic [1:0] o_count
);

    logic        r_in_payload, n_in_payload;
    logic [1:0]  r_digit_count, n_digit_count;
    logic [15:0] r_length_acc, n_length_acc;
    logic [15:0] r_bytes_remaining, n_bytes_remaining;
    logic [15:0] r_declared, n_declared;
    logic [7:0]  r_held_byte, n_held_byte;
    logic        r_held_valid, n_held_valid;

    logic [4:0]  hex;
    logic [15:0] acc_shift;
    logic [15:0] payload_len;
    logic [15:0] remaining_dec;
    t_result     res [MAX_RESULTS];
    logic [1:0]  cnt;

    always_comb begin
        n_in_payload      = r_in_payload;
        n_digit_count     = r_digit_count;
        n_length_acc      = r_length_acc;
        n_bytes_remaining = r_bytes_remaining;
        n_declared        = r_declared;
        n_held_byte       = r_held_byte;
        n_held_valid      = r_held_valid;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '0;
        end
        cnt           = 2'd0;
        hex           = hex_value(i_byte);
        acc_shift     = {r_length_acc[11:0], hex[3:0]};
        payload_len   = acc_shift - HEADER_BYTES;
        remaining_dec = r_bytes_remaining - 16'd1;

        if (i_eoi) begin
            res[0].kind       = i_cfg.eof_is_clean ? KIND_CLEAN : KIND_ERROR;
            res[0].error_code = i_cfg.eof_is_clean ? ERR_CHAR : ERR_HUNGUP;
            cnt               = 2'd1;
            n_in_payload      = 1'b0;
            n_digit_count     = 2'd0;
            n_length_acc      = '0;
            n_held_valid      = 1'b0;
        end else if (!r_in_payload) begin
            if (hex == HEX_INVALID) begin
                res[0].kind       = KIND_ERROR;
                res[0].error_code = ERR_CHAR;
                cnt               = 2'd1;
                n_digit_count     = 2'd0;
                n_length_acc      = '0;
            end else if (r_digit_count != 2'd3) begin
                n_length_acc  = acc_shift;
                n_digit_count = 2'(r_digit_count + 2'd1);
            end else begin
                // Fourth digit: the header is complete.
                n_digit_count = 2'd0;
                n_length_acc  = '0;
                cnt           = 2'd1;
                if (acc_shift == 16'd0) begin
                    res[0].kind = KIND_FLUSH;
                end else if (acc_shift < HEADER_BYTES ||
                             {1'b0, payload_len} >= i_cfg.buffer_size) begin
                    res[0].kind       = KIND_ERROR;
                    res[0].error_code = ERR_LENGTH;
                end else if (acc_shift == HEADER_BYTES) begin
                    res[0].kind = KIND_END;
                end else begin
                    cnt               = 2'd0;
                    n_in_payload      = 1'b1;
                    n_bytes_remaining = payload_len;
                    n_declared        = payload_len;
                end
            end
        end else begin
            // Previous byte goes out now; this one is held back unless it is the last.
            if (r_held_valid) begin
                res[0].kind      = KIND_BYTE;
                res[0].data_byte = r_held_byte;
                cnt              = 2'd1;
            end
            n_held_byte       = i_byte;
            n_held_valid      = 1'b1;
            n_bytes_remaining = remaining_dec;
            if (remaining_dec == 16'd0) begin
                if (i_cfg.chomp_newline && i_byte == CHAR_NEWLINE) begin
                    res[cnt].kind           = KIND_END;
                    res[cnt].payload_length = r_declared - 16'd1;
                    cnt                     = 2'(cnt + 2'd1);
                end else begin
                    res[cnt].kind           = KIND_BYTE;
                    res[cnt].data_byte      = i_byte;
                    res[cnt + 2'd1].kind    = KIND_END;
                    res[cnt + 2'd1].payload_length = r_declared;
                    cnt                     = 2'(cnt + 2'd2);
                end
                n_in_payload = 1'b0;
                n_held_valid = 1'b0;
            end
        end

        if (cnt != 2'd0) begin
            res[cnt - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload  <= 1'b0;
            r_digit_count <= 2'd0;
            r_length_acc  <= '0;
            r_held_valid  <= 1'b0;
        end else if (i_en) begin
            r_in_payload  <= n_in_payload;
            r_digit_count <= n_digit_count;
            r_length_acc  <= n_length_acc;
            r_held_valid  <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bytes_remaining <= n_bytes_remaining;
            r_declared        <= n_declared;
            r_held_byte       <= n_held_byte;
        end
    end

    assign o_res   = res;
    assign o_count = cnt;

endmodule

### hdl/pld_outq.sv
// Four-slot result queue; takes up to three results at once, one out a cycle while popped.
module pld_outq
    import pld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_push_count,
    input  t_result    i_res [MAX_RESULTS],
    input  logic       i_pop,
    output t_result    o_head,
    output t_q_status  o_status
);

    t_result    r_slot [QUEUE_DEPTH];
    t_result    n_slot [QUEUE_DEPTH];
    logic [2:0] r_count, n_count;
    logic [2:0] base;
    logic [2:0] offset;

    always_comb begin
        base   = r_count - {2'b00, i_pop};
        offset = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_pop && i < QUEUE_DEPTH - 1) begin
                n_slot[i] = r_slot[i + 1];
            end else begin
                n_slot[i] = r_slot[i];
            end
            offset = 3'(i) - base;
            if (i_push && 3'(i) >= base && offset < {1'b0, i_push_count}) begin
                n_slot[i] = i_res[offset[1:0]];
            end
        end
        n_count = base + (i_push ? {1'b0, i_push_count} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_head         = r_slot[0];
    assign o_status.count = r_count;
    // Room for a full set of results once this cycle's pop is counted.
    assign o_status.room  = (base <= 3'(QUEUE_DEPTH - MAX_RESULTS));

endmodule
